FILE: src/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/mkd_pkg.sv
package mkd_pkg;

   localparam int COUNTER_BITS_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int THR_W      = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_DOT_MAX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd2;

   localparam logic [15:0] DOT_MAX_RST  = 16'd1500;
   localparam logic [12:0] UNIT_RST     = 13'd800;
   localparam logic [7:0]  DEBOUNCE_RST = 8'd100;

   localparam logic [THR_W-1:0] THR2_RST  = THR_W'(2 * 800);
   localparam logic [THR_W-1:0] THR4_RST  = THR_W'(4 * 800);
   localparam logic [THR_W-1:0] THR12_RST = THR_W'(12 * 800);

   localparam logic [7:0] SYMBOL_EMPTY = 8'h01;
   localparam logic [6:0] CHAR_NONE    = 7'h23;
   localparam int NUM_CODES  = 36;
   localparam int NUM_LETTERS = 26;

   typedef enum logic [2:0] {
      EV_DOT      = 3'd0,
      EV_DASH     = 3'd1,
      EV_CHAR_END = 3'd2,
      EV_CHAR     = 3'd3,
      EV_WORD_END = 3'd4
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [6:0]     character;
   } mkd_event_type;

   typedef struct packed {
      logic          pair;
      mkd_event_type first_ev;
      mkd_event_type second_ev;
   } mkd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mkd_qstat_type;

   localparam logic [7:0] CODE_TABLE [NUM_CODES] = '{
      8'h60, 8'hE8, 8'hA8, 8'hD0, 8'hC0, 8'hB8, 8'h90, 8'hF8, 8'hE0,
      8'h18, 8'h50, 8'hD8, 8'h20, 8'hA0, 8'h10, 8'h98, 8'h48, 8'hB0,
      8'hF0, 8'h40, 8'h70, 8'h78, 8'h30, 8'h68, 8'h28, 8'hC8,
      8'h04, 8'h0C, 8'h1C, 8'h3C, 8'h7C, 8'hFC, 8'hF4, 8'hE4, 8'hC4, 8'h84
   };

   function automatic logic [7:0] rot_right(input logic [7:0] v);
      return {v[0], v[7:1]};
   endfunction

   // The symbol is rotated once more before lookup; the first match wins.
   function automatic logic [6:0] decode_symbol(input logic [7:0] sym);
      logic [7:0] s;
      logic [6:0] ch;
      s  = rot_right(sym);
      ch = CHAR_NONE;
      for (int i = NUM_CODES - 1; i >= 0; i--) begin
         if (CODE_TABLE[i] == s) begin
            if (i < NUM_LETTERS) begin
               ch = 7'(7'h41 + i);
            end else begin
               ch = 7'(7'h30 + (i - NUM_LETTERS));
            end
         end
      end
      return ch;
   endfunction

endpackage

FILE: src/mkd_front.sv
`include "assert_macros.svh"

module mkd_front
   import mkd_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_key_down,
   input  mkd_qstat_type         q_stat,
   output logic                  push,
   output mkd_entry_type         push_entry
);

   localparam int CMP_W = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;

   logic [15:0]             dot_max_ff;
   logic [7:0]              debounce_ff;
   logic [THR_W-1:0]        thr2_ff, thr4_ff, thr12_ff;
   logic [12:0]             unit_eff;

   logic [COUNTER_BITS-1:0] gap_count_ff, gap_count_in;
   logic [COUNTER_BITS-1:0] press_count_ff, press_count_in;
   logic [7:0]              debounce_count_ff, debounce_count_in;
   logic                    pressed_ff, pressed_in;
   logic [7:0]              symbol_bits_ff, symbol_bits_in;
   logic                    char_gap_armed_ff, char_gap_armed_in;
   logic                    word_gap_armed_ff, word_gap_armed_in;

   logic                    accept;
   logic                    release_tick;
   logic                    idle_rearmed;

   assign csr_ready = 1'b1;
   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign unit_eff  = (csr_data[12:0] == '0) ? 13'd1 : csr_data[12:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_max_ff  <= DOT_MAX_RST;
         debounce_ff <= DEBOUNCE_RST;
         thr2_ff     <= THR2_RST;
         thr4_ff     <= THR4_RST;
         thr12_ff    <= THR12_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DOT_MAX: dot_max_ff <= csr_data;
            CSR_UNIT: begin
               thr2_ff  <= {3'b000, unit_eff, 1'b0};
               thr4_ff  <= {2'b00, unit_eff, 2'b00};
               thr12_ff <= THR_W'({unit_eff, 3'b000}) + THR_W'({unit_eff, 2'b00});
            end
            CSR_DEBOUNCE: debounce_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic done;
      done              = 1'b0;
      gap_count_in      = gap_count_ff;
      press_count_in    = press_count_ff;
      debounce_count_in = debounce_count_ff;
      pressed_in        = pressed_ff;
      symbol_bits_in    = symbol_bits_ff;
      char_gap_armed_in = char_gap_armed_ff;
      word_gap_armed_in = word_gap_armed_ff;
      push              = 1'b0;
      push_entry        = '0;

      if (accept) begin
         if (pressed_ff) begin
            done = 1'b1;
            if (req_key_down) begin
               if (press_count_ff != '1) begin
                  press_count_in = press_count_ff + 1'b1;
               end
            end else begin
               pressed_in        = 1'b0;
               gap_count_in      = '0;
               debounce_count_in = '0;
               char_gap_armed_in = 1'b1;
               word_gap_armed_in = 1'b1;
               if (CMP_W'(press_count_ff) < CMP_W'(dot_max_ff)) begin
                  symbol_bits_in           = rot_right(symbol_bits_ff) + 8'd1;
                  push                     = 1'b1;
                  push_entry.first_ev.kind = EV_DOT;
               end else if (CMP_W'(press_count_ff) > CMP_W'(thr2_ff)) begin
                  symbol_bits_in           = rot_right(symbol_bits_ff);
                  push                     = 1'b1;
                  push_entry.first_ev.kind = EV_DASH;
               end
            end
         end else if (req_key_down) begin
            if (debounce_count_ff != 8'hFF) begin
               debounce_count_in = debounce_count_ff + 8'd1;
            end
            if (debounce_count_in >= debounce_ff) begin
               pressed_in     = 1'b1;
               press_count_in = '0;
               gap_count_in   = '0;
               done           = 1'b1;
            end
         end else begin
            debounce_count_in = '0;
         end

         // Idle tick, including a down tick still being debounced.
         if (!done) begin
            if (gap_count_ff != '1) begin
               gap_count_in = gap_count_ff + 1'b1;
            end
            if (CMP_W'(gap_count_in) > CMP_W'(thr4_ff) && char_gap_armed_ff) begin
               push                     = 1'b1;
               push_entry.first_ev.kind = EV_CHAR_END;
               if (symbol_bits_ff != SYMBOL_EMPTY) begin
                  push_entry.pair                = 1'b1;
                  push_entry.second_ev.kind      = EV_CHAR;
                  push_entry.second_ev.character = decode_symbol(symbol_bits_ff);
                  symbol_bits_in                 = SYMBOL_EMPTY;
               end
               char_gap_armed_in = 1'b0;
            end else if (CMP_W'(gap_count_in) > CMP_W'(thr12_ff) && word_gap_armed_ff) begin
               push = 1'b1;
               if (symbol_bits_ff != SYMBOL_EMPTY) begin
                  push_entry.pair               = 1'b1;
                  push_entry.first_ev.kind      = EV_CHAR;
                  push_entry.first_ev.character = decode_symbol(symbol_bits_ff);
                  push_entry.second_ev.kind     = EV_WORD_END;
                  symbol_bits_in                = SYMBOL_EMPTY;
               end else begin
                  push_entry.first_ev.kind = EV_WORD_END;
               end
               word_gap_armed_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_count_ff      <= '0;
         press_count_ff    <= '0;
         debounce_count_ff <= '0;
         pressed_ff        <= 1'b0;
         symbol_bits_ff    <= SYMBOL_EMPTY;
         char_gap_armed_ff <= 1'b1;
         word_gap_armed_ff <= 1'b1;
      end else begin
         gap_count_ff      <= gap_count_in;
         press_count_ff    <= press_count_in;
         debounce_count_ff <= debounce_count_in;
         pressed_ff        <= pressed_in;
         symbol_bits_ff    <= symbol_bits_in;
         char_gap_armed_ff <= char_gap_armed_in;
         word_gap_armed_ff <= word_gap_armed_in;
      end
   end

   assign release_tick = accept && pressed_ff && !req_key_down;
   assign idle_rearmed = !pressed_ff && (gap_count_ff == '0) && char_gap_armed_ff
                         && word_gap_armed_ff;

   `ASSERT_NEXT(fe_release_rearms, clock, reset, release_tick, idle_rearmed)

endmodule

FILE: src/mkd_queue.sv
`include "assert_macros.svh"

module mkd_queue
   import mkd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mkd_entry_type push_entry,
   input  logic          pop,
   output mkd_entry_type head,
   output mkd_qstat_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mkd_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `ASSERT_IMPLY(q_no_overflow, clock, reset, push, !q_stat.full)
   `ASSERT_IMPLY(q_no_underflow, clock, reset, pop, !q_stat.empty)

endmodule

FILE: src/mkd_back.sv
`include "assert_macros.svh"

module mkd_back
   import mkd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mkd_entry_type head,
   input  mkd_qstat_type q_stat,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_event_kind,
   output logic [6:0]    rsp_character,
   output logic          rsp_last
);

   logic          rsp_valid_ff, rsp_valid_in;
   mkd_event_type event_ff, event_in;
   logic          last_ff, last_in;
   logic          sel_ff, sel_in;
   logic          load;

   assign load = !rsp_valid_ff || rsp_ready;

   // A paired entry goes out as two results, first_ev then second_ev; sel_ff marks its second event.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      event_in     = event_ff;
      last_in      = last_ff;
      sel_in       = sel_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            event_in = sel_ff ? head.second_ev : head.first_ev;
            last_in  = sel_ff || !head.pair;
            pop      = sel_ff || !head.pair;
            sel_in   = !(sel_ff || !head.pair);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = event_ff.kind;
   assign rsp_character  = event_ff.character;
   assign rsp_last       = last_ff;

   `ASSERT_IMPLY(bk_second_half, clock, reset, sel_ff, !q_stat.empty && head.pair)

endmodule

FILE: src/morse_key_decoder.sv
// A result enters the queue at the edge that accepts its tick, then the output register
// once it is free. Throughput: one tick per cycle; a tick that yields two results holds the
// output register for both, and the two-entry queue between classifier and output absorbs
// it. Ticks stall only when that queue is full, so the output side sets the long-run rate.
// Reset (synchronous, active high) restores default timing registers, clears all counters,
// arms both gap marks and empties the symbol register and queue.
module morse_key_decoder
   import mkd_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_key_down,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_event_kind,
   output logic [6:0]            rsp_character,
   output logic                  rsp_last
);

   mkd_qstat_type q_stat;
   mkd_entry_type push_entry, head;
   logic          push, pop;

   mkd_front #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_key_down(req_key_down),
      .q_stat      (q_stat),
      .push        (push),
      .push_entry  (push_entry)
   );

   mkd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   mkd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_stat        (q_stat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: dv/morse_key_decoder_test.sv
module morse_key_decoder_test
   import mkd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        key_down;
      int unsigned pause;
   } key_tick_type;

   typedef struct {
      event_kind_type kind;
      logic [6:0]     character;
      logic           last;
   } key_event_type;

   localparam logic [7:0] SYMBOL_NONE = 8'h01;
   localparam logic [6:0] ASCII_A     = 7'h41;
   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_HASH  = 7'h23;
   localparam int         LETTERS     = 26;
   localparam int         PATTERNS    = 36;
   localparam int         LONG_HOLD   = 400;

   // Rotated symbol patterns for A-Z, then 0-9.
   localparam logic [7:0] MORSE_CODES [PATTERNS] = '{
      8'h60, 8'hE8, 8'hA8, 8'hD0, 8'hC0, 8'hB8, 8'h90, 8'hF8, 8'hE0,
      8'h18, 8'h50, 8'hD8, 8'h20, 8'hA0, 8'h10, 8'h98, 8'h48, 8'hB0,
      8'hF0, 8'h40, 8'h70, 8'h78, 8'h30, 8'h68, 8'h28, 8'hC8,
      8'h04, 8'h0C, 8'h1C, 8'h3C, 8'h7C, 8'hFC, 8'hF4, 8'hE4, 8'hC4, 8'h84
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_key_down = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_event_kind;
   logic [6:0]            rsp_character;
   logic                  rsp_last;

   morse_key_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_down   (req_key_down),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

   // Handshakes seen at the last rising edge.
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   bit csr_fire = 1'b0;

   key_tick_type  tick_queue [$];
   key_event_type pending_events [$];
   key_event_type step_events [$];

   int unsigned ticks_planned = 0;
   int unsigned ticks_accepted = 0;
   int unsigned events_seen = 0;
   int unsigned error_count = 0;
   int unsigned holds_asked = 0;

   int unsigned plan_dot_max;
   int unsigned plan_debounce;

   // Decoder state as the checker tracks it.
   logic [15:0] cfg_dot_max;
   logic [12:0] cfg_unit;
   logic [7:0]  cfg_debounce;
   logic [15:0] gap_ticks;
   logic [15:0] press_ticks;
   logic [7:0]  debounce_run;
   logic        key_held;
   logic [7:0]  symbol_reg;
   logic        char_gap_open;
   logic        word_gap_open;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [6:0] letter_for(input logic [7:0] sym);
      logic [7:0] pattern;
      pattern = {sym[0], sym[7:1]};
      for (int i = 0; i < PATTERNS; i++) begin
         if (MORSE_CODES[i] == pattern) begin
            return (i < LETTERS) ? 7'(ASCII_A + i) : 7'(ASCII_ZERO + i - LETTERS);
         end
      end
      return ASCII_HASH;
   endfunction

   function automatic void add_event(input event_kind_type kind, input logic [6:0] ch);
      key_event_type ev;
      ev.kind = kind;
      ev.character = ch;
      ev.last = 1'b0;
      step_events.push_back(ev);
   endfunction

   function automatic void clear_decoder();
      cfg_dot_max = DOT_MAX_RST;
      cfg_unit = UNIT_RST;
      cfg_debounce = DEBOUNCE_RST;
      gap_ticks = '0;
      press_ticks = '0;
      debounce_run = '0;
      key_held = 1'b0;
      symbol_reg = SYMBOL_NONE;
      char_gap_open = 1'b1;
      word_gap_open = 1'b1;
   endfunction

   function automatic void decode_tick(input logic down);
      int unsigned unit_eff;
      int unsigned idx;
      unit_eff = (cfg_unit == 0) ? 1 : int'(cfg_unit);
      step_events.delete();
      if (key_held) begin
         if (down) begin
            if (press_ticks != 16'hFFFF) press_ticks++;
            return;
         end
         key_held = 1'b0;
         gap_ticks = '0;
         debounce_run = '0;
         char_gap_open = 1'b1;
         word_gap_open = 1'b1;
         if (press_ticks < cfg_dot_max) begin
            symbol_reg = {symbol_reg[0], symbol_reg[7:1]} + 8'd1;
            add_event(EV_DOT, 7'd0);
         end else if (int'(press_ticks) > 2 * unit_eff) begin
            symbol_reg = {symbol_reg[0], symbol_reg[7:1]};
            add_event(EV_DASH, 7'd0);
         end
      end else begin
         if (down) begin
            if (debounce_run != 8'hFF) debounce_run++;
            if (debounce_run >= cfg_debounce) begin
               key_held = 1'b1;
               press_ticks = '0;
               gap_ticks = '0;
               return;
            end
         end else begin
            debounce_run = '0;
         end
         if (gap_ticks != 16'hFFFF) gap_ticks++;
         if (int'(gap_ticks) > 4 * unit_eff && char_gap_open) begin
            add_event(EV_CHAR_END, 7'd0);
            if (symbol_reg != SYMBOL_NONE) begin
               add_event(EV_CHAR, letter_for(symbol_reg));
               symbol_reg = SYMBOL_NONE;
            end
            char_gap_open = 1'b0;
         end
         if (step_events.size() == 0 && int'(gap_ticks) > 12 * unit_eff && word_gap_open) begin
            if (symbol_reg != SYMBOL_NONE) begin
               add_event(EV_CHAR, letter_for(symbol_reg));
               symbol_reg = SYMBOL_NONE;
            end
            add_event(EV_WORD_END, 7'd0);
            word_gap_open = 1'b0;
         end
      end
      if (step_events.size() != 0) begin
         idx = step_events.size() - 1;
         step_events[idx].last = 1'b1;
         foreach (step_events[i]) pending_events.push_back(step_events[i]);
      end
   endfunction

   always @(posedge clock) begin : monitor
      key_event_type want;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      csr_fire = !reset && csr_valid && csr_ready;
      if (reset) begin
         clear_decoder();
      end else begin
         if (csr_fire) begin
            case (csr_index)
               CSR_DOT_MAX:  cfg_dot_max = csr_data;
               CSR_UNIT:     cfg_unit = csr_data[12:0];
               CSR_DEBOUNCE: cfg_debounce = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            ticks_accepted++;
            decode_tick(req_key_down);
         end
         if (rsp_fire) begin
            events_seen++;
            if (pending_events.size() == 0) begin
               $error("unexpected result: event_kind %0d character %0d last %0d",
                      rsp_event_kind, rsp_character, rsp_last);
               error_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_kind !== want.kind) begin
                  $error("event_kind: expected %0d, actual %0d", want.kind, rsp_event_kind);
                  error_count++;
               end
               if (rsp_character !== want.character) begin
                  $error("character: expected %0d, actual %0d", want.character, rsp_character);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   // Tick driver: each item waits out its own pause before it is offered.
   key_tick_type staged;
   bit           have_staged = 1'b0;
   int unsigned  pause_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_key_down <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (!have_staged && tick_queue.size() != 0) begin
            staged = tick_queue.pop_front();
            have_staged = 1'b1;
            pause_left = staged.pause;
         end
         if (have_staged && pause_left == 0) begin
            req_valid <= 1'b1;
            req_key_down <= staged.key_down;
            have_staged = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (have_staged) pause_left--;
         end
      end
   end

   // Result receiver: random stalls per item, calm stretches, and long hold-offs on request.
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned rsp_wait = 0;
   bit          rsp_busy = 1'b1;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left = LONG_HOLD;
         end
         if (rsp_fire) begin
            if ($urandom_range(0, 19) == 0) rsp_busy = !rsp_busy;
            rsp_wait = rsp_busy ? $urandom_range(0, 8) : 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic add_ticks(input logic down, input int unsigned count, input bit steady);
      key_tick_type t;
      for (int unsigned i = 0; i < count; i++) begin
         t.key_down = down;
         t.pause = steady ? 0 : $urandom_range(0, 8);
         tick_queue.push_back(t);
         ticks_planned++;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(input int unsigned dot, input int unsigned unit,
                             input int unsigned deb);
      write_reg(CSR_DOT_MAX, 16'(dot));
      write_reg(CSR_UNIT, 16'(unit));
      write_reg(CSR_DEBOUNCE, 16'(deb));
      plan_dot_max = dot;
      plan_debounce = deb;
   endtask

   // Idle means every planned tick was taken and every predicted event came back.
   task automatic wait_idle();
      do @(negedge clock);
      while (ticks_accepted != ticks_planned || pending_events.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned start_ticks, start_events, phase, unit_eff, hold, dot;
      bit steady;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero unit acts as one; a zero debounce accepts on the first down tick.
      set_timing(2, 0, 0);
      add_ticks(1'b0, 1, 1'b0);
      add_ticks(1'b1, 1, 1'b0);
      add_ticks(1'b0, 1, 1'b0);
      add_ticks(1'b1, 4, 1'b0);
      add_ticks(1'b0, 1, 1'b0);
      // A press of exactly two units lies between dot and dash and is dropped.
      add_ticks(1'b1, 3, 1'b0);
      add_ticks(1'b0, 1, 1'b0);
      add_ticks(1'b0, 5, 1'b0);
      add_ticks(1'b0, 8, 1'b0);
      wait_idle();

      // Back-to-back dots while the receiver holds off, so the input side stalls.
      set_timing(16'hFFFF, 1, 0);
      holds_asked++;
      repeat (60) begin
         add_ticks(1'b1, 1, 1'b1);
         add_ticks(1'b0, 1, 1'b1);
      end
      add_ticks(1'b0, 16, 1'b1);
      wait_idle();

      start_ticks = ticks_planned;
      start_events = events_seen;
      phase = 0;
      while ((ticks_planned - start_ticks < 300 || events_seen - start_events < 25)
             && phase < 40) begin
         unit_eff = $urandom_range(1, 6);
         case ($urandom_range(0, 4))
            0: dot = 1;
            1: dot = 16'hFFFF;
            default: dot = $urandom_range(1, 3 * unit_eff + 3);
         endcase
         set_timing(dot, unit_eff, $urandom_range(0, 6));
         repeat ($urandom_range(2, 4)) begin
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 9) == 0) begin
                  // A bounce shorter than the debounce window only adds idle time.
                  if (plan_debounce > 1) begin
                     add_ticks(1'b1, $urandom_range(1, plan_debounce - 1), steady);
                  end
                  add_ticks(1'b0, 1, steady);
               end else begin
                  case ($urandom_range(0, 3))
                     0: hold = $urandom_range(0, 2);
                     1: hold = 2 * unit_eff + $urandom_range(0, 1);
                     2: hold = (plan_dot_max <= 64) ? plan_dot_max - 1 + $urandom_range(0, 1)
                                                    : $urandom_range(0, 3 * unit_eff + 2);
                     default: hold = $urandom_range(0, 3 * unit_eff + 2);
                  endcase
                  add_ticks(1'b1, (plan_debounce == 0) ? 1 : plan_debounce, steady);
                  add_ticks(1'b1, hold, steady);
                  add_ticks(1'b0, 1, steady);
               end
               add_ticks(1'b0, $urandom_range(0, 3 * unit_eff), steady);
            end
            if ($urandom_range(0, 2) == 0) begin
               add_ticks(1'b0, $urandom_range(12 * unit_eff + 1, 12 * unit_eff + 4), steady);
            end else begin
               add_ticks(1'b0, $urandom_range(4 * unit_eff + 1, 8 * unit_eff), steady);
            end
         end
         wait_idle();
         phase++;
      end

      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #8ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
